@@ rtl/srsw_pkg.sv @@
// ----------------------------------------------------------------------------
// srsw_pkg: shared types and constants for the selective-repeat sender
// Item types, control and status structs between controller and datapath,
// and the slot ring index helper.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int WINDOW_MAX    = 16;
  localparam int SLOT_BITS     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_BITS      = $clog2(WINDOW_MAX + 1);
  localparam int WS_BITS       = 5;
  localparam int TIME_BITS     = 32;
  localparam int BASE_BITS     = 17;
  localparam int FRAME_BITS    = 16;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  localparam logic [WS_BITS-1:0]   WS_RESET      = 5'd4;
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_TICK  = 2'd1,
    OP_ACK   = 2'd2,
    OP_NAK   = 2'd3
  } op_t;

  typedef enum logic [REG_IDX_BITS-1:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_TIMEOUT     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] frame_count;
    logic        final_buffer;
    logic [15:0] ack_seq;
    logic        ack_checksum_ok;
  } op_item_t;

  typedef struct packed {
    logic [15:0] send_seq;
    logic        end_of_transfer;
    logic        last_of_run;
    logic        buffer_done;
  } send_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic slide;
    logic clr_idx;
    logic inc_idx;
    logic take;
    logic flush;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic op_tick;
    logic head_acked;
    logic idx_lt_ws;
    logic scan_end;
    logic due;
    logic pend_valid;
    logic out_free;
  } sts_t;

  // physical slot of logical offset b from ring head a
  function automatic logic [SLOT_BITS-1:0] wrap_slot(input logic [SLOT_BITS-1:0] a,
                                                     input logic [CNT_BITS-1:0]  b);
    logic [CNT_BITS:0] sum;
    sum = (CNT_BITS+1)'(a) + (CNT_BITS+1)'(b);
    if (sum >= (CNT_BITS+1)'(WINDOW_MAX)) begin
      sum = sum - (CNT_BITS+1)'(WINDOW_MAX);
    end
    return sum[SLOT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/srsw_ram.sv @@
// ----------------------------------------------------------------------------
// srsw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/srsw_regs.sv @@
// ----------------------------------------------------------------------------
// srsw_regs: configuration registers
// APB-style write/read of window size and resend timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_regs (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srsw_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [srsw_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [srsw_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready,
  output logic      [srsw_pkg::WS_BITS-1:0]        window_size,
  output logic      [srsw_pkg::TIME_BITS-1:0]      timeout_ticks
);

  import srsw_pkg::*;

  logic     wr;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WS_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (wr) begin
      unique case (reg_idx)
        REG_WINDOW_SIZE: window_size   <= pwdata[WS_BITS-1:0];
        REG_TIMEOUT:     timeout_ticks <= pwdata[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_SIZE: prdata = APB_DATA_BITS'(window_size);
      REG_TIMEOUT:     prdata = APB_DATA_BITS'(timeout_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/srsw_ctrl.sv @@
// ----------------------------------------------------------------------------
// srsw_ctrl: sequencer for the sender window
// Accepts requests, walks the slide and the send scan one slot per cycle, the scan holding while the send side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           op_valid,
  output logic                op_stall,
  input  wire srsw_pkg::sts_t sts,
  output srsw_pkg::ctl_t      ctl
);

  import srsw_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SLIDE = 4'b0010,
    ST_EVAL  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign op_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.accept = op_valid;
        if (op_valid && sts.op_tick) begin
          ctl.clr_idx = 1'b1;
          state_next  = ST_SLIDE;
        end
      end
      ST_SLIDE: begin
        if (sts.idx_lt_ws && sts.head_acked) begin
          ctl.slide   = 1'b1;
          ctl.inc_idx = 1'b1;
        end else begin
          ctl.clr_idx = 1'b1;
          state_next  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.scan_end) begin
          state_next = ST_FLUSH;
        end else if (sts.due) begin
          // hold while the older request cannot move out
          if (!sts.pend_valid || sts.out_free) begin
            ctl.take    = 1'b1;
            ctl.inc_idx = 1'b1;
          end
        end else begin
          ctl.inc_idx = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!sts.pend_valid) begin
          state_next = ST_IDLE;
        end else if (sts.out_free) begin
          ctl.flush  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_slide_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SLIDE) && !sts.idx_lt_ws |=> state == ST_EVAL)
    else $error("slide ran past the window");

  a_take_room: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> (!sts.pend_valid || sts.out_free))
    else $error("request taken with no room to retire the pending one");

  a_flush_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) && !sts.pend_valid |=> state == ST_IDLE)
    else $error("flush stuck with nothing pending");

endmodule

`default_nettype wire

@@ rtl/srsw_dp.sv @@
// ----------------------------------------------------------------------------
// srsw_dp: window datapath
// Slot flags on a ring, send-time RAM, base and clock, pending and output
// request registers.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_dp (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire srsw_pkg::op_item_t               op_item,
  input  wire logic [srsw_pkg::WS_BITS-1:0]     window_size,
  input  wire logic [srsw_pkg::TIME_BITS-1:0]   timeout_ticks,
  input  wire srsw_pkg::ctl_t                   ctl,
  output srsw_pkg::sts_t                        sts,
  output logic                                  send_valid,
  input  wire logic                             send_stall,
  output srsw_pkg::send_item_t                  send_item
);

  import srsw_pkg::*;

  logic [BASE_BITS-1:0]  base;
  logic [FRAME_BITS-1:0] frames;
  logic                  final_flag;
  logic [TIME_BITS-1:0]  tick_clock;
  logic [SLOT_BITS-1:0]  head;
  logic [CNT_BITS-1:0]   idx;
  logic [CNT_BITS-1:0]   idx_next;
  logic [WINDOW_MAX-1:0] acked;
  logic [WINDOW_MAX-1:0] sent;
  logic [WINDOW_MAX-1:0] resend;
  logic                  pend_valid;
  send_item_t            pend_item;
  send_item_t            new_item;
  send_item_t            out_item;

  logic [CNT_BITS-1:0]   ws_live;
  logic [SLOT_BITS-1:0]  slot;
  logic [SLOT_BITS-1:0]  rd_slot;
  logic [BASE_BITS:0]    seq;
  logic [TIME_BITS-1:0]  sent_time;
  logic [TIME_BITS-1:0]  age;
  logic                  idx_lt_ws;
  logic                  out_free;
  logic                  load_out;

  logic                  op_start;
  logic                  op_tick;
  logic                  op_acknak;
  logic [BASE_BITS-1:0]  ack_off;
  logic [SLOT_BITS-1:0]  ack_slot;
  logic                  ack_hit;

  // window size 0 acts as 1, oversize clamps to the built depth
  always_comb begin
    if (window_size == '0) begin
      ws_live = CNT_BITS'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      ws_live = CNT_BITS'(WINDOW_MAX);
    end else begin
      ws_live = CNT_BITS'(window_size);
    end
  end

  always_comb begin
    if (ctl.clr_idx) begin
      idx_next = '0;
    end else if (ctl.inc_idx) begin
      idx_next = idx + CNT_BITS'(1);
    end else begin
      idx_next = idx;
    end
  end

  assign slot      = wrap_slot(head, idx);
  assign rd_slot   = wrap_slot(head, idx_next);
  assign seq       = (BASE_BITS+1)'(base) + (BASE_BITS+1)'(idx);
  assign idx_lt_ws = idx < ws_live;
  assign age       = tick_clock - sent_time;
  assign out_free  = !send_valid || !send_stall;

  assign op_start  = (op_item.operation == OP_START);
  assign op_tick   = (op_item.operation == OP_TICK);
  assign op_acknak = (op_item.operation == OP_ACK) || (op_item.operation == OP_NAK);
  assign ack_off   = BASE_BITS'(op_item.ack_seq) - base;
  assign ack_slot  = wrap_slot(head, CNT_BITS'(ack_off));
  assign ack_hit   = op_acknak && op_item.ack_checksum_ok
                  && (BASE_BITS'(op_item.ack_seq) >= base)
                  && (op_item.ack_seq < frames)
                  && (ack_off < BASE_BITS'(ws_live))
                  && sent[ack_slot];

  always_comb begin
    sts            = '0;
    sts.op_tick    = op_tick;
    sts.head_acked = acked[head];
    sts.idx_lt_ws  = idx_lt_ws;
    sts.scan_end   = !idx_lt_ws || (seq >= (BASE_BITS+1)'(frames));
    // an acknowledged slot is never resent
    sts.due        = !sent[slot]
                  || (!acked[slot] && (resend[slot] || (age > timeout_ticks)));
    sts.pend_valid = pend_valid;
    sts.out_free   = out_free;
  end

  always_comb begin
    new_item                 = '0;
    new_item.send_seq        = seq[15:0];
    new_item.end_of_transfer = final_flag
                            && ((seq + (BASE_BITS+1)'(1)) == (BASE_BITS+1)'(frames));
    new_item.last_of_run     = 1'b0;
    new_item.buffer_done     = base >= BASE_BITS'(frames);
  end

  // flag the request that the flush moves out as the last of the tick
  always_comb begin
    out_item             = pend_item;
    out_item.last_of_run = ctl.flush;
  end

  assign load_out = (ctl.take || ctl.flush) && pend_valid;

  srsw_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_send_time (
    .clk   (clk),
    .we    (ctl.take),
    .waddr (slot),
    .wdata (tick_clock),
    .raddr (rd_slot),
    .rdata (sent_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base       <= '0;
      frames     <= '0;
      final_flag <= 1'b0;
      tick_clock <= '0;
      head       <= '0;
      idx        <= '0;
      acked      <= '0;
      sent       <= '0;
      resend     <= '0;
      pend_valid <= 1'b0;
      send_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (ctl.accept && op_start) begin
        frames     <= op_item.frame_count;
        final_flag <= op_item.final_buffer;
        base       <= '0;
        head       <= '0;
        acked      <= '0;
        sent       <= '0;
        resend     <= '0;
      end
      if (ctl.accept && op_tick) begin
        tick_clock <= tick_clock + TIME_BITS'(1);
      end
      if (ctl.accept && ack_hit) begin
        if (op_item.operation == OP_ACK) begin
          acked[ack_slot] <= 1'b1;
        end else begin
          resend[ack_slot] <= 1'b1;
        end
      end
      // advance by one slot; the freed slot becomes the new tail, cleared
      if (ctl.slide) begin
        acked[head]  <= 1'b0;
        sent[head]   <= 1'b0;
        resend[head] <= 1'b0;
        head         <= wrap_slot(head, CNT_BITS'(1));
        base         <= base + BASE_BITS'(1);
      end
      if (ctl.take) begin
        sent[slot]   <= 1'b1;
        resend[slot] <= 1'b0;
        pend_valid   <= 1'b1;
      end else if (ctl.flush) begin
        pend_valid <= 1'b0;
      end
      if (load_out) begin
        send_valid <= 1'b1;
      end else if (!send_stall) begin
        send_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      pend_item <= new_item;
    end
    if (load_out) begin
      send_item <= out_item;
    end
  end

  a_slide_acked: assert property (@(posedge clk) disable iff (rst)
    ctl.slide |-> acked[head])
    else $error("slide over an unacknowledged slot");

  a_take_marks_sent: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> sent[$past(slot)] && !resend[$past(slot)])
    else $error("taken slot not marked sent");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    ctl.flush && pend_valid |=> send_valid && send_item.last_of_run && !pend_valid)
    else $error("final request of a tick not flagged");

endmodule

`default_nettype wire

@@ rtl/selective_repeat_sender_window.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_sender_window: sender side of a selective-repeat window
// Start, tick, ack and nak requests in; send requests out, one per frame due.
// ----------------------------------------------------------------------------
// Start, ack and nak are applied as they are accepted and leave op_stall low.
// A tick slides the window past the acked slots at its head, then scans the
// live window for due slots, one slot per cycle through the slide and the scan;
// the scan holds on a due slot while the send side stalls.
// Send requests leave through a pending register and an output register.
// Synchronous reset clears the window, base, clock and flags; no clearing pass.
`default_nettype none

module selective_repeat_sender_window (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                op_valid,
  output logic                                     op_stall,
  input  wire srsw_pkg::op_item_t                  op_item,
  output logic                                     send_valid,
  input  wire logic                                send_stall,
  output srsw_pkg::send_item_t                     send_item,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [srsw_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire logic [srsw_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic      [srsw_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                     pready
);

  import srsw_pkg::*;

  logic [WS_BITS-1:0]   window_size;
  logic [TIME_BITS-1:0] timeout_ticks;
  ctl_t                 ctl;
  sts_t                 sts;

  srsw_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_size   (window_size),
    .timeout_ticks (timeout_ticks)
  );

  srsw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op_stall (op_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  srsw_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .op_item       (op_item),
    .window_size   (window_size),
    .timeout_ticks (timeout_ticks),
    .ctl           (ctl),
    .sts           (sts),
    .send_valid    (send_valid),
    .send_stall    (send_stall),
    .send_item     (send_item)
  );

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the selective-repeat sender window
// Drives start, tick, ack and nak requests with random gaps while the send
// side stalls at random. A behavioral copy of the window, advanced on every
// accepted request, supplies the send requests each tick must produce. A
// short directed table runs first. Random buffers then run under several
// window and timeout settings, written over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import srsw_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int DIR_ROWS       = 24;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 30;

  typedef struct packed {
    op_t         op;
    logic [15:0] frames;
    logic        fin;
    logic [15:0] seq;
    logic        ok;
    logic        typed;
    logic [4:0]  n_sends;
    logic [15:0] first_seq;
    logic        eot_last;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic op_valid;
  logic op_stall;
  op_item_t op_item;
  logic send_valid;
  logic send_stall = 1'b0;
  send_item_t send_item;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  // window state as the block should hold it
  logic [16:0] win_base;
  logic [15:0] buf_frames;
  logic buf_final;
  logic [WINDOW_MAX-1:0] slot_ack;
  logic [WINDOW_MAX-1:0] slot_sent;
  logic [WINDOW_MAX-1:0] slot_nak;
  logic [31:0] slot_time [WINDOW_MAX];
  logic [31:0] tick_count;
  logic [4:0] cfg_ws;
  logic [31:0] cfg_timeout;

  send_item_t tick_sends[$];
  send_item_t due_sends[$];

  int err_count = 0;
  int idle_cycles = 0;
  int op_calm = 0;
  int stall_left = 0;
  int calm_left = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_START, 16'd3,     1'b1, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd3, 16'd0, 1'b1},
    '{OP_ACK,   16'd0,     1'b0, 16'd1,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_NAK,   16'd0,     1'b0, 16'd0,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd0,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd2,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd1,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_NAK,   16'd0,     1'b0, 16'd1,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'hFFFF,  1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_START, 16'hFFFF,  1'b1, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd4, 16'd0, 1'b0},
    '{OP_NAK,   16'd0,     1'b0, 16'd7,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd0,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_ACK,   16'd0,     1'b0, 16'd1,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b0, 5'd0, 16'd0, 1'b0},
    '{OP_START, 16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_START, 16'd5,     1'b1, 16'd0,     1'b0, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_NAK,   16'd0,     1'b0, 16'd2,     1'b1, 1'b1, 5'd0, 16'd0, 1'b0},
    '{OP_TICK,  16'd0,     1'b0, 16'd0,     1'b0, 1'b1, 5'd4, 16'd0, 1'b0}
  };

  logic [31:0] phase_ws [PHASES] = '{32'd1, 32'd16, 32'd31, 32'd3, 32'd0, 32'd16, 32'd9};
  logic [31:0] phase_to [PHASES] = '{32'd1, 32'd2, 32'hFFFF_FFFF, 32'd4, 32'd6, 32'd1,
                                     32'hFFFF_FFFF};

  selective_repeat_sender_window u_top (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (op_valid),
    .op_stall   (op_stall),
    .op_item    (op_item),
    .send_valid (send_valid),
    .send_stall (send_stall),
    .send_item  (send_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int live_ws();
    if (cfg_ws == 5'd0) return 1;
    if (int'(cfg_ws) > WINDOW_MAX) return WINDOW_MAX;
    return int'(cfg_ws);
  endfunction

  task automatic clear_window();
    int i;
    slot_ack = '0;
    slot_sent = '0;
    slot_nak = '0;
    for (i = 0; i < WINDOW_MAX; i++) slot_time[i] = '0;
  endtask

  // Advance the window by one request; a tick leaves its sends in tick_sends.
  task automatic sender_step(input op_item_t it);
    int ws;
    int run;
    int i;
    int seq;
    int off;
    logic due;
    send_item_t s;
    send_item_t tail;
    ws = live_ws();
    tick_sends.delete();
    case (it.operation)
      OP_START: begin
        buf_frames = it.frame_count;
        buf_final = it.final_buffer;
        win_base = '0;
        clear_window();
      end
      OP_ACK, OP_NAK: begin
        if (it.ack_checksum_ok && {1'b0, it.ack_seq} >= win_base &&
            it.ack_seq < buf_frames) begin
          off = int'({1'b0, it.ack_seq} - win_base);
          if (off < ws && slot_sent[off]) begin
            if (it.operation == OP_ACK) slot_ack[off] = 1'b1;
            else slot_nak[off] = 1'b1;
          end
        end
      end
      default: begin
        tick_count = tick_count + 32'd1;
        run = 0;
        while (run < ws && slot_ack[run]) run++;
        if (run > 0) begin
          slot_ack = slot_ack >> run;
          slot_sent = slot_sent >> run;
          slot_nak = slot_nak >> run;
          for (i = 0; i < WINDOW_MAX; i++) begin
            if (i + run < WINDOW_MAX) slot_time[i] = slot_time[i + run];
            else slot_time[i] = '0;
          end
          win_base = win_base + 17'(run);
        end
        for (i = 0; i < ws; i++) begin
          seq = int'(win_base) + i;
          if (seq >= int'(buf_frames)) break;
          if (!slot_sent[i]) due = 1'b1;
          else if (slot_ack[i]) due = 1'b0;
          else due = slot_nak[i] || ((tick_count - slot_time[i]) > cfg_timeout);
          if (due) begin
            s.send_seq = 16'(seq);
            s.end_of_transfer = buf_final && (seq + 1 == int'(buf_frames));
            s.last_of_run = 1'b0;
            s.buffer_done = (win_base >= {1'b0, buf_frames});
            tick_sends.push_back(s);
            slot_sent[i] = 1'b1;
            slot_nak[i] = 1'b0;
            slot_time[i] = tick_count;
          end
        end
        if (tick_sends.size() > 0) begin
          tail = tick_sends.pop_back();
          tail.last_of_run = 1'b1;
          tick_sends.push_back(tail);
        end
      end
    endcase
  endtask

  // Mostly requests that move the current buffer along, some noise.
  function automatic op_item_t next_request();
    op_item_t it;
    int r;
    int ws_now;
    ws_now = live_ws();
    it.operation = 2'(OP_TICK);
    it.frame_count = 16'($urandom());
    it.final_buffer = 1'($urandom());
    it.ack_seq = 16'($urandom());
    it.ack_checksum_ok = 1'($urandom());
    r = $urandom_range(0, 99);
    if ({1'b0, buf_frames} <= win_base || r < 3) begin
      it.operation = OP_START;
      r = $urandom_range(0, 9);
      if (r < 8) it.frame_count = 16'($urandom_range(1, 40));
      else if (r == 8) it.frame_count = 16'($urandom_range(0, 3));
    end else if (r < 45) begin
      it.operation = OP_TICK;
    end else if (r < 88) begin
      it.operation = (r < 78) ? OP_ACK : OP_NAK;
      it.ack_seq = 16'(int'(win_base) + $urandom_range(0, ws_now));
      it.ack_checksum_ok = ($urandom_range(0, 99) < 92);
    end else begin
      it.operation = 2'($urandom_range(2, 3));
    end
    return it;
  endfunction

  task automatic note_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  // Enter at a clock edge; return at the edge where the request was taken.
  task automatic issue_request(input op_item_t it, input bit typed, input int n_sends,
                               input logic [15:0] first_seq, input bit eot_last);
    int gap;
    int r;
    int k;
    send_item_t s;
    gap = 0;
    if (op_calm > 0) begin
      op_calm--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) gap = 0;
      else if (r < 80) gap = $urandom_range(1, 3);
      else if (r < 95) gap = $urandom_range(4, 12);
      else if (r < 98) gap = $urandom_range(20, 60);
      else op_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      op_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op_valid <= 1'b1;
    op_item <= it;
    do @(posedge clk); while (op_stall);
    sender_step(it);
    if (typed) begin
      for (k = 0; k < n_sends; k++) begin
        s.send_seq = first_seq + 16'(k);
        s.end_of_transfer = eot_last && (k == n_sends - 1);
        s.last_of_run = (k == n_sends - 1);
        s.buffer_done = 1'b0;
        due_sends.push_back(s);
      end
    end else begin
      foreach (tick_sends[k]) due_sends.push_back(tick_sends[k]);
    end
  endtask

  // Hold requests until every send has come out and the block has gone quiet.
  task automatic drain_sends();
    op_valid <= 1'b0;
    @(posedge clk);
    while (due_sends.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WINDOW_SIZE) cfg_ws = data[4:0];
    else cfg_timeout = data;
  endtask

  // random send-side stalls, with calm stretches
  always @(posedge clk) begin
    if (calm_left > 0) begin
      calm_left--;
      send_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      send_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:59]: send_stall <= 1'b0;
        [60:89]: begin
          stall_left = $urandom_range(0, 2);
          send_stall <= 1'b1;
        end
        [90:96]: begin
          stall_left = $urandom_range(10, 40);
          send_stall <= 1'b1;
        end
        default: begin
          calm_left = $urandom_range(50, 300);
          send_stall <= 1'b0;
        end
      endcase
    end
  end

  // check each send request and watch for a hang
  always @(posedge clk) begin
    send_item_t want;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (send_valid && !send_stall) begin
        if (due_sends.size() == 0) begin
          note_mismatch($sformatf("unexpected send: seq=%0d eot=%0b last=%0b done=%0b",
                                  send_item.send_seq, send_item.end_of_transfer,
                                  send_item.last_of_run, send_item.buffer_done));
        end else begin
          want = due_sends.pop_front();
          if (send_item.send_seq !== want.send_seq ||
              send_item.end_of_transfer !== want.end_of_transfer ||
              send_item.last_of_run !== want.last_of_run ||
              send_item.buffer_done !== want.buffer_done) begin
            note_mismatch($sformatf({"send mismatch: exp seq=%0d eot=%0b last=%0b done=%0b",
                                     " got seq=%0d eot=%0b last=%0b done=%0b"},
                                    want.send_seq, want.end_of_transfer,
                                    want.last_of_run, want.buffer_done,
                                    send_item.send_seq, send_item.end_of_transfer,
                                    send_item.last_of_run, send_item.buffer_done));
          end
        end
      end
      if ((op_valid && !op_stall) || (send_valid && !send_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    op_item_t it;
    int r;
    int p;
    int k;
    rst = 1'b1;
    op_valid = 1'b0;
    op_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    win_base = '0;
    buf_frames = '0;
    buf_final = 1'b0;
    tick_count = '0;
    cfg_ws = WS_RESET;
    cfg_timeout = TIMEOUT_RESET;
    clear_window();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < DIR_ROWS; r++) begin
      it.operation = dir_rows[r].op;
      it.frame_count = dir_rows[r].frames;
      it.final_buffer = dir_rows[r].fin;
      it.ack_seq = dir_rows[r].seq;
      it.ack_checksum_ok = dir_rows[r].ok;
      issue_request(it, dir_rows[r].typed, int'(dir_rows[r].n_sends),
                    dir_rows[r].first_seq, dir_rows[r].eot_last);
    end

    for (p = 0; p < PHASES; p++) begin
      drain_sends();
      apb_write(REG_WINDOW_SIZE, phase_ws[p]);
      apb_write(REG_TIMEOUT, phase_to[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        issue_request(next_request(), 1'b0, 0, '0, 1'b0);
        if ($urandom_range(0, 39) == 0) drain_sends();
      end
    end

    drain_sends();
    if (err_count == 0 && due_sends.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ selective_repeat_sender_window.f @@
rtl/srsw_pkg.sv
rtl/srsw_ram.sv
rtl/srsw_regs.sv
rtl/srsw_ctrl.sv
rtl/srsw_dp.sv
rtl/selective_repeat_sender_window.sv
tb/tb_top.sv
